/* design/hbcs_pkg.sv */
// ---------------------------------------------------------------------------
// hbcs_pkg: shared types and constants for the host bridge config space
// Item structs, window byte copies, request codes and reset contents.
// ---------------------------------------------------------------------------
package hbcs_pkg;

    typedef struct packed {
        logic       req_type;
        logic [2:0] func_num;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        aperture_on;
        logic [9:0]  aperture_base_field;
        logic [6:0]  aperture_size_units;
        logic [19:0] mchbar_base_field;
        logic        smram_global_on;
        logic        smram_open;
        logic        smram_closed;
        logic        high_smram_on;
        logic        tseg_enable;
        logic [14:0] tseg_base_field;
        logic [1:0]  tseg_size_code;
    } rsp_t;

    // Bytes the window decode needs, held in flops beside the byte store.
    typedef struct packed {
        logic [7:0] b12;
        logic [7:0] b13;
        logic [7:0] b15;
        logic [7:0] b16;
        logic [7:0] b17;
        logic [7:0] b51;
        logic [7:0] b9d;
        logic [7:0] b9e;
        logic [7:0] bb4;
        logic [7:0] bc4;
        logic [7:0] bc5;
    } win_t;

    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;
    localparam logic [2:0] HOST_FUNC = 3'd0;

    localparam logic [15:0] TOM_MASK = 16'hfff0;
    localparam logic [15:0] TOM_MIN  = 16'h0200;

    // TOM reset value is that of 256 MB.
    localparam win_t WIN_RESET = '{b12: 8'h00, b13: 8'h00, b15: 8'h00, b16: 8'h00,
                                   b17: 8'h00, b51: 8'h00, b9d: 8'h02, b9e: 8'h38,
                                   bb4: 8'h00, bc4: 8'h00, bc5: 8'h10};

    // Reset contents of the space, TOM excluded.
    function automatic logic [7:0] reset_byte(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'h86;
            8'h01: r = 8'h80;
            8'h02: r = 8'h30;
            8'h03: r = 8'h1a;
            8'h04: r = 8'h06;
            8'h06: r = 8'h90;
            8'h08: r = 8'h04;
            8'h0b: r = 8'h06;
            8'h10: r = 8'h08;
            8'h34: r = 8'ha0;
            8'h78: r = 8'h10;
            8'h9d: r = 8'h02;
            8'h9e: r = 8'h38;
            8'ha0: r = 8'h02;
            8'ha2: r = 8'h20;
            8'ha4: r = 8'h17;
            8'ha5: r = 8'h02;
            8'ha7: r = 8'h1f;
            8'he4: r = 8'h09;
            8'he5: r = 8'ha0;
            8'he6: r = 8'h04;
            8'he7: r = 8'hf1;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Default TOM from installed memory.
    function automatic logic [15:0] default_tom(input logic [11:0] mb);
        logic [15:0] t;
        t = {mb, 4'h0};
        return (t < TOM_MIN) ? TOM_MIN : t;
    endfunction

endpackage

/* design/hbcs_regs.sv */
// ---------------------------------------------------------------------------
// hbcs_regs: configuration byte store with write rules
// Registered input item, byte update per register rules, write-once bits.
// Bytes 0x00..0xff live in a memory loaded by a pass over every address after reset;
// the bytes the decode needs are kept in flops as well.
// ---------------------------------------------------------------------------
module hbcs_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  hbcs_pkg::req_t req,
    input  logic [11:0]    mem_mb,
    output hbcs_pkg::win_t win,
    output logic           loading,
    output logic           done,
    output logic [7:0]     rd_data
);
    import hbcs_pkg::*;

    logic [7:0]  mem [256];
    logic [7:0]  mem_q;
    req_t        req_reg;
    logic        vld_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;
    logic        clr_reg;
    logic [7:0]  clr_idx_reg;
    win_t        win_reg, win_next;
    logic [7:0]  b0_reg, b0_next;
    logic [3:0]  sub_reg, sub_next;
    logic        done_reg;
    logic [7:0]  rd_reg, rd_next;
    logic [31:0] ab;
    logic [15:0] treg, dt;
    logic [7:0]  a, v, c, s, n;
    logic        wr;

    assign win     = win_reg;
    assign loading = clr_reg;
    assign done    = done_reg;
    assign rd_data = rd_reg;

    always_comb
    begin
        a = req_reg.reg_addr;
        v = req_reg.write_data;
        case (a)
            8'h12:   c = win_reg.b12;
            8'h13:   c = win_reg.b13;
            8'h15:   c = win_reg.b15;
            8'h16:   c = win_reg.b16;
            8'h17:   c = win_reg.b17;
            8'h51:   c = win_reg.b51;
            8'h9d:   c = win_reg.b9d;
            8'h9e:   c = win_reg.b9e;
            8'hb0:   c = b0_reg;
            8'hb4:   c = win_reg.bb4;
            8'hc4:   c = win_reg.bc4;
            8'hc5:   c = win_reg.bc5;
            default: c = fwd_reg ? fwd_data_reg : mem_q;
        endcase
        s        = 8'h00;
        n        = c;
        ab       = 32'h0;
        treg     = 16'h0;
        dt       = 16'h0;
        win_next = win_reg;
        b0_next  = b0_reg;
        sub_next = sub_reg;
        wr       = vld_reg && (req_reg.req_type == REQ_WRITE) &&
                   (req_reg.func_num == HOST_FUNC);
        rd_next  = 8'h00;
        if (vld_reg && (req_reg.req_type == REQ_READ)) begin
            if (req_reg.func_num != HOST_FUNC)
                rd_next = 8'hff;
            else if (a == 8'ha4 && b0_reg[0])
                rd_next = {c[7:3], 3'b001};
            else
                rd_next = c;
        end
        if (wr) begin
            if (a >= 8'h2c && a <= 8'h2f) begin
                if (!sub_reg[a[1:0]]) begin
                    n                = v;
                    sub_next[a[1:0]] = 1'b1;
                end
            end else if ((a >= 8'h60 && a <= 8'h67) ||
                         (a >= 8'h80 && a <= 8'h8b && a != 8'h86) ||
                         a == 8'h16 || a == 8'h17 || a == 8'hba || a == 8'hbb ||
                         a == 8'hc5 || a == 8'hde || a == 8'hdf || a == 8'hff) begin
                n = v;
            end else if (a >= 8'h70 && a <= 8'h72) begin
                n = v & 8'h77;
            end else if (a >= 8'h91 && a <= 8'h96) begin
                n = v & 8'h33;
            end else if (a >= 8'hb1 && a <= 8'hb3) begin
                n = 8'h00;
            end else begin
                case (a)
                    8'h05: n = v & 8'h01;
                    8'h07: n = c & ~(v & 8'h70);
                    8'h12, 8'h13: n = v;
                    8'h14, 8'h73, 8'h7b, 8'haa, 8'hab, 8'hb8,
                    8'hcd, 8'hcf, 8'hf4, 8'hf5, 8'hf7: n = 8'h00;
                    8'h15: n = v & 8'hf0;
                    8'h51: n = v & 8'h02;
                    8'h78: n = v & 8'h35;
                    8'h79: n = v & 8'h06;
                    8'h7a, 8'h7d: n = v & 8'h07;
                    8'h7c: n = v & 8'h70;
                    8'h7e, 8'h7f, 8'h90: n = v & 8'h30;
                    8'h97: n = v & 8'h80;
                    8'h9d:
                    begin
                        if (c[4]) begin
                            n = (c & ~8'h20) | (v & 8'h20) | 8'h02;
                        end else begin
                            s = (v & 8'h78) | 8'h02;
                            if (s[4])
                                s[6] = 1'b0;
                            n = s;
                        end
                    end
                    8'h9e:
                    begin
                        if (win_reg.b9d[4])
                            n = (c & ~(v & 8'h40)) | 8'h38;
                        else
                            n = ((c & 8'h40) & ~(v & 8'h40)) | (v & 8'h87) | 8'h38;
                    end
                    8'ha8: n = v & 8'h17;
                    8'ha9, 8'hcc, 8'hce: n = v & 8'h03;
                    8'hb0: n = v & 8'h81;
                    8'hb4: n = v & 8'h3f;
                    8'hb9: n = v & 8'hf0;
                    8'hbc, 8'hbd: n = v & 8'hf8;
                    8'hc4: n = v & 8'hf0;
                    8'hc6: n = (c & 8'h04) | (v & 8'h22);
                    8'hc7: n = v & 8'h08;
                    8'hc8, 8'hc9: n = c & ~v;
                    8'hca: n = v & 8'h7f;
                    8'hcb: n = v & 8'h02;
                    8'hf6: n = v & 8'h40;
                    8'hfe: n = v & 8'h0c;
                    default: n = c;
                endcase
            end
            case (a)
                8'h12:   win_next.b12 = n;
                8'h13:   win_next.b13 = n;
                8'h15:   win_next.b15 = n;
                8'h16:   win_next.b16 = n;
                8'h17:   win_next.b17 = n;
                8'h51:   win_next.b51 = n;
                8'h9d:   win_next.b9d = n;
                8'h9e:   win_next.b9e = n;
                8'hb0:   b0_next      = n;
                8'hb4:   win_next.bb4 = n;
                8'hc4:   win_next.bc4 = n;
                8'hc5:   win_next.bc5 = n;
                default: ;
            endcase
            // aperture re-mask; bytes 0x10/0x11 already hold 08/00
            if (a == 8'h12 || a == 8'h13 || a == 8'h51 || a == 8'hb4) begin
                ab = {win_next.b13, win_next.b12, 16'h0000}
                     & ({4'hf, win_next.bb4[5:0], 22'h0});
                win_next.b12 = ab[23:16];
                win_next.b13 = ab[31:24];
            end
            if (a == 8'hc4 || a == 8'hc5) begin
                treg = {win_next.bc5, win_next.bc4};
                if (treg < TOM_MIN) begin
                    dt = default_tom(mem_mb);
                    win_next.bc4 = dt[7:0];
                    win_next.bc5 = dt[15:8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_reg      <= '0;
            vld_reg      <= 1'b0;
            fwd_reg      <= 1'b0;
            fwd_data_reg <= 8'h00;
            clr_reg      <= 1'b1;
            clr_idx_reg  <= 8'h00;
            win_reg      <= WIN_RESET;
            b0_reg       <= 8'h00;
            sub_reg      <= '0;
            done_reg     <= 1'b0;
            rd_reg       <= 8'h00;
        end else begin
            if (in_valid)
                req_reg <= req;
            vld_reg      <= in_valid;
            fwd_reg      <= wr && (req.reg_addr == a);
            fwd_data_reg <= n;
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + 8'd1;
                if (clr_idx_reg == 8'hff)
                    clr_reg <= 1'b0;
            end
            win_reg  <= win_next;
            b0_reg   <= b0_next;
            sub_reg  <= sub_next;
            done_reg <= vld_reg;
            rd_reg   <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q <= mem[req.reg_addr];
        if (clr_reg)
            mem[clr_idx_reg] <= reset_byte(clr_idx_reg);
        else if (wr)
            mem[a] <= n;
    end

endmodule

/* design/hbcs_decode.sv */
// ---------------------------------------------------------------------------
// hbcs_decode: window decode and result register
// Derives aperture, MCHBAR and SMRAM/TSEG state from the stored space.
// ---------------------------------------------------------------------------
module hbcs_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  hbcs_pkg::win_t win,
    input  logic           done,
    input  logic [7:0]     rd_data,
    input  logic [11:0]    mem_mb,
    output hbcs_pkg::rsp_t rsp,
    output logic           strobe
);
    import hbcs_pkg::*;

    rsp_t        rsp_reg, rsp_next;
    logic        strobe_reg;
    logic [31:0] ab;
    logic [15:0] tom_f, tom;   // TOM in 64 KB units
    logic [15:0] mem_u;
    logic [15:0] tsize;        // in 64 KB units
    logic [15:0] tdiff;
    logic [7:0]  sm, esm;
    logic        tseg;

    assign rsp    = rsp_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        sm    = win.b9d;
        esm   = win.b9e;
        ab    = {win.b13, win.b12, 16'h0} & {4'hf, win.bb4[5:0], 22'h0};
        mem_u = {mem_mb, 4'h0};
        tom_f = {win.bc5, win.bc4} & TOM_MASK;
        tom   = (tom_f == 16'h0 || tom_f > mem_u) ? mem_u : tom_f;
        tsize = 16'h0002 << esm[2:1];
        tseg  = sm[3] && esm[0] && (tom != 16'h0) && (tom >= tsize);
        tdiff = tom - tsize;
        rsp_next.read_data           = rd_data;
        rsp_next.aperture_on         = win.b51[1] && (ab != 32'h0);
        rsp_next.aperture_base_field = ab[31:22];
        rsp_next.aperture_size_units = {1'b0, ~win.bb4[5:0]} + 7'd1;
        rsp_next.mchbar_base_field   = {win.b17, win.b16, win.b15[7:4]};
        rsp_next.smram_global_on     = sm[3];
        rsp_next.smram_open          = (sm[6] && !sm[4]);
        rsp_next.smram_closed        = sm[5];
        rsp_next.high_smram_on       = sm[3] && esm[7];
        rsp_next.tseg_enable         = tseg;
        rsp_next.tseg_base_field     = tseg ? tdiff[15:1] : 15'h0;
        rsp_next.tseg_size_code      = tseg ? esm[2:1] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            strobe_reg <= 1'b0;
            rsp_reg    <= '0;
        end else begin
            strobe_reg <= done;
            rsp_reg    <= rsp_next;
        end
    end

endmodule

/* design/host_bridge_config_space.sv */
// ---------------------------------------------------------------------------
// host_bridge_config_space: byte-wide PCI host bridge configuration space
// Top level: command port, memory size register and two pipeline stages.
// ---------------------------------------------------------------------------
// Usage:
//   An item (req) is taken at a clock edge with start high and busy low.
//   After reset busy stays high while the byte store is loaded with its
//   reset contents; after that busy is low for good.
//   Stage one registers the item and reads the byte store, then applies the
//   read or write; stage two decodes the aperture, MCHBAR and SMRAM/TSEG
//   windows from the updated space. The result (rsp) is marked by done for
//   one cycle, after the item, stage-one and decode registers. The receiver
//   cannot stall; every item gives one result; one item per cycle.
//   cfg_we writes memory_size_mb (MB of installed memory) from cfg_wdata;
//   write it only while no item is in flight.
//   Reset loads the ID bytes, defaults and the TOM for 256 MB, clears the
//   write-once subsystem flags and sets memory_size_mb to 256.
// ---------------------------------------------------------------------------
module host_bridge_config_space (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hbcs_pkg::req_t   req,
    output logic             done,
    output hbcs_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [11:0]      cfg_wdata
);
    import hbcs_pkg::*;

    logic [11:0] mem_mb_reg;
    win_t        win;
    logic        loading;
    logic        s1_done;
    logic [7:0]  s1_rd;

    assign busy = loading;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_mb_reg <= 12'd256;
        else if (cfg_we)
            mem_mb_reg <= cfg_wdata;
    end

    hbcs_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !loading),
        .req      (req),
        .mem_mb   (mem_mb_reg),
        .win      (win),
        .loading  (loading),
        .done     (s1_done),
        .rd_data  (s1_rd)
    );

    hbcs_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .win     (win),
        .done    (s1_done),
        .rd_data (s1_rd),
        .mem_mb  (mem_mb_reg),
        .rsp     (rsp),
        .strobe  (done)
    );

endmodule
